### src/wstq_pkg.sv
// Shared constants, codes and transaction types for the work-stealing task queue unit.
package wstq_pkg;

	// Sizing
	localparam int NUM_CORES     = 8;
	localparam int QUEUE_DEPTH   = 16;
	localparam int TASK_ID_WIDTH = 16;

	// Fixed field widths
	localparam int CORE_W   = 3;
	localparam int TASK_W   = 16;
	localparam int STATUS_W = 2;

	// Derived widths
	localparam int CIDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int HD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W  = HD_W + 1;

	// Operation codes
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic              operation;
		logic [CORE_W-1:0] core;
		logic [TASK_W-1:0] task_in;
	} wstq_in_t;

	typedef struct packed {
		logic [TASK_W-1:0]   task_out;
		logic                found;
		logic [CORE_W-1:0]   source_queue;
		logic                stolen;
		logic [STATUS_W-1:0] status;
	} wstq_out_t;

endpackage

### src/work_stealing_task_queues_unit.sv
// Work-stealing task queue unit: per-core task queues with a sequential stealing scan.
//
// One bounded queue of task identifiers per core. A push transaction appends to the back of
// the named queue (status full and the task dropped when there is no room); a fetch takes the
// front of the core's own queue, or, if that is empty and stealing is enabled, the back entry
// of the first non-empty queue in the order core+1, core+2, ... modulo the core count. Each
// transaction is accepted only while the sequencer is idle and produces one result. The
// sequencer examines one queue per cycle through a single counter compare and a single
// queue memory port. A push, a fetch served from the core's own queue, or a fetch with
// stealing disabled is settled on the scan step of its own queue; the response state then
// loads the output register and the sequencer returns to idle for the next transaction.
// A fetch that steals scans the queues in turn until one yields an entry; a fetch that
// finds nothing scans all NUM_CORES queues before its empty result. A finished result sits
// in an output register, so the next transaction may be accepted while it waits; a new
// result is held back for as long as the previous one is still unaccepted in that
// register. No clearing pass follows reset.
module work_stealing_task_queues_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wstq_pkg::wstq_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output wstq_pkg::wstq_out_t out_data,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data
);
	import wstq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t state_q;

	// Configuration
	logic steal_en_q;

	// Latched transaction
	logic              op_q;
	logic [CORE_W-1:0] core_q;
	logic [TASK_W-1:0] task_q;

	// Scan sequencer
	logic [CIDX_W-1:0] scan_q;
	logic [CIDX_W-1:0] step_q;
	logic              steal_q;

	// Queue bookkeeping and storage
	logic [HD_W-1:0]   head_q  [NUM_CORES];
	logic [CNT_W-1:0]  count_q [NUM_CORES];
	logic [TASK_W-1:0] mem_q   [NUM_CORES][QUEUE_DEPTH];
	logic [TASK_W-1:0] rd_q;

	// Result held until handed to the output register
	logic                res_found_q;
	logic                res_stolen_q;
	logic [CIDX_W-1:0]   res_src_q;
	logic [STATUS_W-1:0] res_status_q;

	logic out_valid_q;

	// Combinational view of the queue under examination
	logic [CNT_W-1:0]  cnt;
	logic [HD_W-1:0]   hd;
	logic [HD_W-1:0]   hd_inc;
	logic [SUM_W-1:0]  sum;
	logic [HD_W-1:0]   slot;
	logic [CIDX_W-1:0] scan_nxt;
	logic              is_push;
	logic              core_ok;
	logic              hit;
	logic              full;
	logic              mem_we;
	logic              take;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign cnt     = count_q[scan_q];
	assign hd      = head_q[scan_q];
	assign is_push = (op_q == OP_PUSH);
	assign core_ok = (core_q < NUM_CORES);
	assign hit     = (cnt != '0);
	assign full    = (cnt >= CNT_W'(QUEUE_DEPTH));
	assign hd_inc  = (hd == HD_W'(QUEUE_DEPTH - 1)) ? '0 : hd + 1'b1;
	assign scan_nxt = (scan_q == CIDX_W'(NUM_CORES - 1)) ? '0 : scan_q + 1'b1;

	// A push stores, a fetch takes an entry, on this scan step
	assign mem_we = (state_q == ST_SCAN) && is_push && core_ok && !full;
	assign take   = (state_q == ST_SCAN) && !is_push && core_ok && hit;

	// Slot arithmetic: back for push, front for own fetch, last entry for a steal
	always_comb begin
		sum = {1'b0, hd};
		if (is_push) begin
			sum = sum + SUM_W'(cnt);
		end else if (steal_q) begin
			sum = sum + SUM_W'(cnt) - 1'b1;
		end
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			slot = HD_W'(sum - SUM_W'(QUEUE_DEPTH));
		end else begin
			slot = HD_W'(sum);
		end
	end

	// Queue memory, one port
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			if (mem_we) begin
				mem_q[scan_q][slot] <= task_q;
			end
			rd_q <= mem_q[scan_q][slot];
		end
	end

	// Transaction latch
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= in_data.operation;
			core_q <= in_data.core;
			task_q <= in_data.task_in;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steal_en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			steal_en_q <= cfg_wr_data;
		end
	end

	// Sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			step_q  <= '0;
			steal_q <= 1'b0;
			for (int i = 0; i < NUM_CORES; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						scan_q  <= CIDX_W'(in_data.core);
						step_q  <= '0;
						steal_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (is_push) begin
						if (mem_we) begin
							count_q[scan_q] <= cnt + 1'b1;
						end
						state_q <= ST_RESP;
					end else if (take) begin
						count_q[scan_q] <= cnt - 1'b1;
						if (!steal_q) begin
							head_q[scan_q] <= hd_inc;
						end
						state_q <= ST_RESP;
					end else if (!core_ok || !steal_en_q ||
							step_q == CIDX_W'(NUM_CORES - 1)) begin
						state_q <= ST_RESP;
					end else begin
						scan_q  <= scan_nxt;
						step_q  <= step_q + 1'b1;
						steal_q <= 1'b1;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result capture at the end of the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			res_found_q  <= take;
			res_stolen_q <= take && steal_q;
			res_src_q    <= take ? scan_q : '0;
			if (is_push) begin
				res_status_q <= mem_we ? STATUS_OK : STATUS_FULL;
			end else begin
				res_status_q <= take ? STATUS_OK : STATUS_EMPTY;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
			out_data.task_out     <= res_found_q ? rd_q : '0;
			out_data.found        <= res_found_q;
			out_data.source_queue <= CORE_W'(res_src_q);
			out_data.stolen       <= res_stolen_q;
			out_data.status       <= res_status_q;
		end
	end

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> count_q[$past(scan_q)] == $past(cnt) + 1'b1)
		else $error("stored push did not grow the queue");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> step_q <= CIDX_W'(NUM_CORES - 1))
		else $error("scan ran past the last queue");

	a_steal_other: assert property (@(posedge clk) disable iff (!arst_n)
		take && steal_q |-> scan_q != CIDX_W'(core_q))
		else $error("steal taken from the requesting core");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESP && res_found_q |-> res_status_q == STATUS_OK)
		else $error("found result without ok status");

endmodule

### tb/wstq_checker.sv
// Checker for the work-stealing task queue unit: tracks queue contents and compares results.
module wstq_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  wstq_pkg::wstq_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  wstq_pkg::wstq_out_t out_data,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	output int                  mismatch_count,
	output int                  results_owed
);
	import wstq_pkg::*;

	localparam int OWED_DEPTH = 4;

	// Shadow copy of every core queue
	logic [TASK_W-1:0] slot_task [NUM_CORES][QUEUE_DEPTH];
	int unsigned       front_slot [NUM_CORES];
	int unsigned       depth_used [NUM_CORES];
	logic              stealing_on;

	// Results owed by the unit, oldest first, in a small ring
	wstq_out_t         owed_ring [OWED_DEPTH];
	wstq_out_t         owed_head;
	int unsigned       owed_rd_ptr = 0;
	int unsigned       owed_wr_ptr = 0;
	int                fails = 0;
	int                owed_now = 0;

	assign mismatch_count = fails;
	assign results_owed   = owed_now;

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch @%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
		fails++;
	endtask

	// Apply one push or fetch to the shadow queues and return the result it should give
	function automatic wstq_out_t dispatch_item(wstq_in_t item);
		wstq_out_t   res;
		int unsigned own;
		int unsigned victim;
		int unsigned slot;
		res = '0;
		own = item.core;
		if (item.operation == OP_PUSH) begin
			if (own >= NUM_CORES || depth_used[own] >= QUEUE_DEPTH) begin
				res.status = STATUS_FULL;
			end else begin
				slot = (front_slot[own] + depth_used[own]) % QUEUE_DEPTH;
				slot_task[own][slot] = item.task_in;
				depth_used[own]++;
				res.status = STATUS_OK;
			end
			return res;
		end
		if (own >= NUM_CORES) begin
			res.status = STATUS_EMPTY;
			return res;
		end
		// own queue first, from the front
		if (depth_used[own] > 0) begin
			res.task_out     = slot_task[own][front_slot[own]];
			res.found        = 1'b1;
			res.source_queue = CORE_W'(own);
			front_slot[own]  = (front_slot[own] + 1) % QUEUE_DEPTH;
			depth_used[own]--;
			res.status = STATUS_OK;
			return res;
		end
		// steal from the back of the next non-empty queue, wrapping round
		if (stealing_on) begin
			for (int i = 1; i < NUM_CORES; i++) begin
				victim = (own + i) % NUM_CORES;
				if (!res.found && depth_used[victim] > 0) begin
					slot = (front_slot[victim] + depth_used[victim] - 1) % QUEUE_DEPTH;
					res.task_out     = slot_task[victim][slot];
					res.found        = 1'b1;
					res.source_queue = CORE_W'(victim);
					res.stolen       = 1'b1;
					depth_used[victim]--;
				end
			end
		end
		res.status = res.found ? STATUS_OK : STATUS_EMPTY;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_CORES; q++) begin
				front_slot[q] = 0;
				depth_used[q] = 0;
			end
			stealing_on = 1'b1;
			owed_rd_ptr = 0;
			owed_wr_ptr = 0;
			owed_now = 0;
		end else begin
			if (cfg_wr_en)
				stealing_on = cfg_wr_data;
			// compare a delivered result with the oldest one owed
			if (out_valid && out_ready) begin
				if (owed_now == 0) begin
					report_mismatch("result with none owed, status", out_data.status, 0);
				end else begin
					owed_head   = owed_ring[owed_rd_ptr];
					owed_rd_ptr = (owed_rd_ptr + 1) % OWED_DEPTH;
					owed_now--;
					if (out_data.task_out !== owed_head.task_out)
						report_mismatch("task_out", out_data.task_out, owed_head.task_out);
					if (out_data.found !== owed_head.found)
						report_mismatch("found", out_data.found, owed_head.found);
					if (out_data.source_queue !== owed_head.source_queue)
						report_mismatch("source_queue", out_data.source_queue,
							owed_head.source_queue);
					if (out_data.stolen !== owed_head.stolen)
						report_mismatch("stolen", out_data.stolen, owed_head.stolen);
					if (out_data.status !== owed_head.status)
						report_mismatch("status", out_data.status, owed_head.status);
				end
			end
			// every accepted transaction owes exactly one result
			if (in_valid && in_ready) begin
				if (owed_now >= OWED_DEPTH) begin
					report_mismatch("results owed beyond ring, count", owed_now, OWED_DEPTH);
				end else begin
					owed_ring[owed_wr_ptr] = dispatch_item(in_data);
					owed_wr_ptr = (owed_wr_ptr + 1) % OWED_DEPTH;
					owed_now++;
				end
			end
		end
	end

endmodule

### tb/tb_work_stealing_task_queues_unit.sv
// Testbench top for the work-stealing task queue unit: stimulus, handshake pacing and verdict.
module tb_work_stealing_task_queues_unit;
	import wstq_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = NUM_CORES + 8;
	localparam int RANDOM_ITEMS = 1200;
	localparam int SEGMENTS     = 6;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      in_valid    = 1'b0;
	logic      in_ready;
	wstq_in_t  in_data     = '0;
	logic      out_valid;
	logic      out_ready   = 1'b0;
	wstq_out_t out_data;
	logic      cfg_wr_en   = 1'b0;
	logic      cfg_wr_data = 1'b0;

	int send_idle_pct = 23;
	int recv_idle_pct = 75;
	int cycle_count   = 0;
	int mismatch_count;
	int results_owed;

	work_stealing_task_queues_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	wstq_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Result side back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("work_stealing_task_queues_unit test failed");
			$finish;
		end
	end

	// Offer one transaction after a random gap and hold it until taken
	task automatic send_item(logic op, logic [CORE_W-1:0] core_idx, logic [TASK_W-1:0] task_id);
		wstq_in_t item;
		item.operation = op;
		item.core      = core_idx;
		item.task_in   = task_id;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Stop sending until every owed result is out and the sequencer has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_steal(logic value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int               push_pct;
		logic [CORE_W-1:0] hot_core;
		logic [CORE_W-1:0] core_pick;
		logic              op_pick;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: nothing anywhere, field extremes, own fetch, steal, wrap-round steal
		send_item(OP_FETCH, 3'd0, 16'hFFFF);
		send_item(OP_PUSH, 3'd0, 16'hFFFF);
		send_item(OP_PUSH, 3'd0, 16'h0000);
		send_item(OP_PUSH, 3'd7, 16'hA5A5);
		send_item(OP_PUSH, 3'd7, 16'h5A5A);
		send_item(OP_FETCH, 3'd0, 16'h1234);
		send_item(OP_FETCH, 3'd3, 16'h0000);
		send_item(OP_FETCH, 3'd7, 16'h0000);
		send_item(OP_FETCH, 3'd7, 16'h0000);
		// fill one queue to the brim, then one push too many
		for (int k = 0; k < QUEUE_DEPTH + 1; k++)
			send_item(OP_PUSH, 3'd5, TASK_W'($urandom));
		// stealing off: an empty core gets nothing though another queue is full
		write_steal(1'b0);
		send_item(OP_FETCH, 3'd1, 16'h0000);
		send_item(OP_FETCH, 3'd5, 16'h0000);

		// Random: pacing profile changes every two segments, stealing alternates
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			write_steal(seg % 2 == 0);
			send_idle_pct = (seg < 2) ? 23 : (seg < 4) ? 75 : 0;
			recv_idle_pct = (seg < 2) ? 75 : (seg < 4) ? 23 : 0;
			for (int n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) begin
				// swing between filling and draining, with one busy core
				if (n % 40 == 0) begin
					case ($urandom_range(2))
						0: push_pct = 15;
						1: push_pct = 50;
						default: push_pct = 85;
					endcase
					hot_core = CORE_W'($urandom_range(NUM_CORES - 1));
				end
				if (n == 100)
					wait_idle();
				op_pick   = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_FETCH;
				core_pick = ($urandom_range(1) != 0) ? hot_core :
					CORE_W'($urandom_range(NUM_CORES - 1));
				send_item(op_pick, core_pick, TASK_W'($urandom));
			end
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("work_stealing_task_queues_unit test passed");
		else
			$display("work_stealing_task_queues_unit test failed");
		$finish;
	end

endmodule

### work_stealing_task_queues_unit.f
src/wstq_pkg.sv
src/work_stealing_task_queues_unit.sv
tb/wstq_checker.sv
tb/tb_work_stealing_task_queues_unit.sv
